### design/drrip_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the DRRIP/SHiP replacement policy.
// No dependencies; every other design file imports this package.
package drrip_pkg;

  localparam int OP_W   = 1;
  localparam int SETF_W = 11;
  localparam int WAYF_W = 4;
  localparam int PCF_W  = 6;
  localparam int ADF_W  = 6;
  localparam int VICT_W = 4;
  localparam int BIM_W  = 5;

  localparam logic [OP_W-1:0] OP_FIND   = 1'b0;
  localparam logic [OP_W-1:0] OP_UPDATE = 1'b1;

  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] RRPV_LONG = 2'd2;
  localparam logic [1:0] RRPV_NEAR = 2'd0;
  localparam logic [1:0] CNT_MAX   = 2'd3;
  localparam logic [1:0] CNT_REUSE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;   // write reset values at the sweep index, advance it
    logic load_req;   // capture the accepted beat
    logic reduce;     // fold set and way into range by one step
    logic rd_rows;    // read the RRPV and signature rows of the set
    logic find_wr;    // write aged row back, load result register
    logic hit_wr;     // promote block, read counter of new signature
    logic old_rd;     // read counter of the evicted block's signature
    logic cnt_inc;    // write incremented counter
    logic cnt_dec;    // write decremented counter, read new signature's
    logic miss_wr;    // choose insertion RRPV, write rows, train selector
  } drrip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic in_range;
    logic is_find;
    logic is_hit;
    logic out_busy;
  } drrip_sts_t;

endpackage

### design/drrip_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and victim results.
// Depends on drrip_pkg for field widths.
interface drrip_req_if;
  import drrip_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SETF_W-1:0] set_index;
  logic [WAYF_W-1:0] way_index;
  logic              hit;
  logic [PCF_W-1:0]  pc_bits;
  logic [ADF_W-1:0]  addr_bits;
  modport source (output valid, opcode, set_index, way_index, hit, pc_bits, addr_bits,
                  input ready);
  modport sink (input valid, opcode, set_index, way_index, hit, pc_bits, addr_bits,
                output ready);
endinterface

interface drrip_rsp_if;
  import drrip_pkg::*;
  logic              valid;
  logic              ready;
  logic [VICT_W-1:0] victim_way;
  modport source (output valid, victim_way, input ready);
  modport sink (input valid, victim_way, output ready);
endinterface

### design/drrip_ship_replacement_policy.sv
`timescale 1ns / 1ps
// Top level of the DRRIP replacement policy with SHiP signature insertion.
// Depends on drrip_pkg, drrip_if, drrip_ctrl and drrip_dp.
//
// Usage:
//  - req (sink): one beat is a request. opcode find-victim names a set and
//    returns one beat on rsp; opcode update trains the policy and returns
//    nothing.
//  - rsp (source): victim_way, the lowest way whose RRPV reached 3 after
//    aging the set.
//  - A request is taken when idle, then walks a short sequence on the
//    single-port row memories: find-victim reads and ages the set row;
//    a hit update also raises the reuse counter of the new signature; a
//    miss update lowers the evicted block's counter, then inserts. Sets
//    or ways beyond the configured counts are first folded into range.
//  - The victim sits in an output register; the next request is taken
//    while it waits. A second find-victim holds in its write-back step
//    until the receiver takes the earlier victim.
//  - After reset the block sweeps its memories, one row per cycle, over
//    max(NUM_SETS, 2^SIG_WIDTH) rows (2048 by default) with ready low.
module drrip_ship_replacement_policy #(
  parameter int NUM_SETS     = 2048,
  parameter int NUM_WAYS     = 16,
  parameter int SIG_WIDTH    = 6,
  parameter int SEL_WIDTH    = 10,
  parameter int LEADER_COUNT = 64
) (
  input logic        clk,
  input logic        rst,
  drrip_req_if.sink  req,
  drrip_rsp_if.source rsp
);
  import drrip_pkg::*;

  drrip_cmd_t cmd;
  drrip_sts_t sts;

  // sequencer: sweep, then one request at a time
  drrip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // memories, counters and the victim output register
  drrip_dp #(
    .NUM_SETS     (NUM_SETS),
    .NUM_WAYS     (NUM_WAYS),
    .SIG_WIDTH    (SIG_WIDTH),
    .SEL_WIDTH    (SEL_WIDTH),
    .LEADER_COUNT (LEADER_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (req.opcode),
    .set_index  (req.set_index),
    .way_index  (req.way_index),
    .hit        (req.hit),
    .pc_bits    (req.pc_bits),
    .addr_bits  (req.addr_bits),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .victim_way (rsp.victim_way)
  );

endmodule

### design/drrip_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the replacement policy: clearing sweep and per-request steps.
// Depends on drrip_pkg for the command and status structs.
module drrip_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  drrip_pkg::drrip_sts_t sts,
  output drrip_pkg::drrip_cmd_t cmd
);
  import drrip_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RED  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_EX   = 4'd4;
  localparam logic [3:0] S_HINC = 4'd5;
  localparam logic [3:0] S_MDEC = 4'd6;
  localparam logic [3:0] S_MINS = 4'd7;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else     state <= state_next;
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_RED;
        end
      end
      S_RED: begin
        if (sts.in_range) begin
          cmd.rd_rows = 1'b1;
          state_next  = S_RD;
        end else begin
          cmd.reduce = 1'b1;
        end
      end
      S_RD: state_next = S_EX;
      S_EX: begin
        if (sts.is_find) begin
          // hold until the result register can take the victim
          if (!sts.out_busy) begin
            cmd.find_wr = 1'b1;
            state_next  = S_IDLE;
          end
        end else if (sts.is_hit) begin
          cmd.hit_wr = 1'b1;
          state_next = S_HINC;
        end else begin
          cmd.old_rd = 1'b1;
          state_next = S_MDEC;
        end
      end
      S_HINC: begin
        cmd.cnt_inc = 1'b1;
        state_next  = S_IDLE;
      end
      S_MDEC: begin
        cmd.cnt_dec = 1'b1;
        state_next  = S_MINS;
      end
      S_MINS: begin
        cmd.miss_wr = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule

### design/drrip_dp.sv
`timescale 1ns / 1ps
// Datapath: RRPV and signature row memories, reuse counters, selector.
// Depends on drrip_pkg for widths, codes and the command/status structs.
module drrip_dp #(
  parameter int NUM_SETS     = 2048,
  parameter int NUM_WAYS     = 16,
  parameter int SIG_WIDTH    = 6,
  parameter int SEL_WIDTH    = 10,
  parameter int LEADER_COUNT = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  drrip_pkg::drrip_cmd_t          cmd,
  output drrip_pkg::drrip_sts_t          sts,
  input  logic [drrip_pkg::OP_W-1:0]     opcode,
  input  logic [drrip_pkg::SETF_W-1:0]   set_index,
  input  logic [drrip_pkg::WAYF_W-1:0]   way_index,
  input  logic                           hit,
  input  logic [drrip_pkg::PCF_W-1:0]    pc_bits,
  input  logic [drrip_pkg::ADF_W-1:0]    addr_bits,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [drrip_pkg::VICT_W-1:0]   victim_way
);
  import drrip_pkg::*;

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int WAY_W   = (NUM_WAYS > 2) ? $clog2(NUM_WAYS) : 1;
  localparam int NSIG    = 1 << SIG_WIDTH;
  localparam int CLR_N   = (NUM_SETS > NSIG) ? NUM_SETS : NSIG;
  localparam int CLR_W   = $clog2(CLR_N + 1);
  localparam int RROW_W  = 2 * NUM_WAYS;
  localparam int SROW_W  = SIG_WIDTH * NUM_WAYS;
  localparam logic [SEL_WIDTH-1:0] SEL_MID = {1'b1, {(SEL_WIDTH-1){1'b0}}};
  localparam logic [SEL_WIDTH-1:0] SEL_MAX = '1;

  logic [RROW_W-1:0]    rrpv_mem [NUM_SETS];
  logic [SROW_W-1:0]    sig_mem  [NUM_SETS];
  logic [1:0]           cnt_mem  [NSIG];

  logic [CLR_W-1:0]     clr_idx;
  logic [OP_W-1:0]      op_r;
  logic [SETF_W-1:0]    set_r;
  logic [WAYF_W-1:0]    way_r;
  logic                 hit_r;
  logic [SIG_WIDTH-1:0] sig_r;
  logic [RROW_W-1:0]    rrpv_q;
  logic [SROW_W-1:0]    sig_q;
  logic [1:0]           cnt_q;
  logic                 fwd;
  logic [1:0]           dec_val;
  logic [SEL_WIDTH-1:0] psel;
  logic [BIM_W-1:0]     bim;

  logic [SET_W-1:0]     set_a;
  logic [WAY_W-1:0]     way_a;
  logic [SIG_WIDTH-1:0] old_sig;
  logic [1:0]           top, lift;
  logic [RROW_W-1:0]    aged;
  logic [WAY_W-1:0]     vict;
  logic                 row_we;
  logic [SET_W-1:0]     row_addr;
  logic [RROW_W-1:0]    rrpv_wd;
  logic [SROW_W-1:0]    sig_wd;
  logic                 cnt_we;
  logic [SIG_WIDTH-1:0] cnt_wa;
  logic [1:0]           cnt_wd;
  logic                 cnt_re;
  logic [SIG_WIDTH-1:0] cnt_ra;
  logic                 lead_s, lead_b, use_srrip;
  logic [1:0]           new_cnt, ins;
  logic [BIM_W-1:0]     bim_inc;

  assign set_a   = SET_W'(set_r);
  assign way_a   = WAY_W'(way_r);
  assign old_sig = sig_q[way_a*SIG_WIDTH +: SIG_WIDTH];

  assign sts.clr_done = (clr_idx == CLR_W'(CLR_N - 1));
  assign sts.in_range = (set_r < SETF_W'(NUM_SETS - 1) + 1'b1 || NUM_SETS > (1 << SETF_W) - 1)
                        && (32'(way_r) < NUM_WAYS);
  assign sts.is_find  = (op_r == OP_FIND);
  assign sts.is_hit   = hit_r;
  assign sts.out_busy = out_valid && !out_ready;

  // aging: raise every way by the distance of the oldest one to the maximum
  always_comb begin
    top  = '0;
    vict = '0;
    for (int w = 0; w < NUM_WAYS; w++)
      if (rrpv_q[2*w +: 2] > top) top = rrpv_q[2*w +: 2];
    lift = RRPV_MAX - top;
    for (int w = 0; w < NUM_WAYS; w++)
      aged[2*w +: 2] = rrpv_q[2*w +: 2] + lift;
    for (int w = NUM_WAYS - 1; w >= 0; w--)
      if (aged[2*w +: 2] == RRPV_MAX) vict = WAY_W'(w);
  end

  assign lead_s    = (32'(set_r) < LEADER_COUNT / 2);
  assign lead_b    = !lead_s && (32'(set_r) < LEADER_COUNT);
  assign use_srrip = lead_s || (!lead_b && psel >= SEL_MID);
  assign new_cnt   = fwd ? dec_val : cnt_q;
  assign bim_inc   = bim + 1'b1;

  always_comb begin
    if (new_cnt >= CNT_REUSE) ins = RRPV_NEAR;
    else if (use_srrip)       ins = RRPV_LONG;
    else                      ins = (bim_inc == '0) ? RRPV_LONG : RRPV_MAX;
  end

  // row write port
  always_comb begin
    row_we   = 1'b0;
    row_addr = set_a;
    rrpv_wd  = rrpv_q;
    sig_wd   = sig_q;
    if (cmd.clr_step) begin
      row_we   = (32'(clr_idx) < NUM_SETS);
      row_addr = SET_W'(clr_idx);
      rrpv_wd  = '1;
      sig_wd   = '0;
    end else if (cmd.find_wr) begin
      row_we  = 1'b1;
      rrpv_wd = aged;
    end else if (cmd.hit_wr || cmd.miss_wr) begin
      row_we = 1'b1;
      rrpv_wd[way_a*2 +: 2]                = cmd.hit_wr ? RRPV_NEAR : ins;
      sig_wd[way_a*SIG_WIDTH +: SIG_WIDTH] = sig_r;
    end
  end

  // counter ports
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = sig_r;
    cnt_wd = cnt_q;
    cnt_re = 1'b0;
    cnt_ra = sig_r;
    if (cmd.clr_step) begin
      cnt_we = (32'(clr_idx) < NSIG);
      cnt_wa = SIG_WIDTH'(clr_idx);
      cnt_wd = '0;
    end else if (cmd.hit_wr) begin
      cnt_re = 1'b1;
    end else if (cmd.old_rd) begin
      cnt_re = 1'b1;
      cnt_ra = old_sig;
    end else if (cmd.cnt_inc) begin
      cnt_we = 1'b1;
      cnt_wd = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt_we = 1'b1;
      cnt_wa = old_sig;
      cnt_wd = (cnt_q == '0) ? cnt_q : cnt_q - 1'b1;
      cnt_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      rrpv_mem[row_addr] <= rrpv_wd;
      sig_mem[row_addr]  <= sig_wd;
    end
    if (cmd.rd_rows) begin
      rrpv_q <= rrpv_mem[set_a];
      sig_q  <= sig_mem[set_a];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= opcode;
      set_r <= set_index;
      way_r <= way_index;
      hit_r <= hit;
      sig_r <= SIG_WIDTH'(pc_bits ^ addr_bits);
    end else if (cmd.reduce) begin
      if (32'(set_r) >= NUM_SETS) set_r <= set_r - SETF_W'(NUM_SETS);
      if (32'(way_r) >= NUM_WAYS) way_r <= way_r - WAYF_W'(NUM_WAYS);
    end
    if (cmd.cnt_dec) begin
      fwd     <= (old_sig == sig_r);
      dec_val <= cnt_wd;
    end
    if (cmd.find_wr) victim_way <= VICT_W'(vict);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      psel      <= SEL_MID;
      bim       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_idx <= clr_idx + 1'b1;
      if (cmd.miss_wr) begin
        if (new_cnt < CNT_REUSE && !use_srrip) bim <= bim_inc;
        if (lead_s && psel != '0)          psel <= psel - 1'b1;
        else if (lead_b && psel != SEL_MAX) psel <= psel + 1'b1;
      end
      if (cmd.find_wr)     out_valid <= 1'b1;
      else if (out_ready)  out_valid <= 1'b0;
    end
  end

endmodule
